>>> hdl/sssc_pkg.sv
// ----------------------------------------------------------------------------
// sssc_pkg
// Shared types, constants and the segment lookup for the stopwatch counter.
// ----------------------------------------------------------------------------
`default_nettype none

package sssc_pkg;

  // number of decimal digits kept in the count
  localparam int DIGIT_COUNT = 4;
  // digits that fit in the 32-bit segment word
  localparam int SHOWN_DIGITS = (DIGIT_COUNT < 4) ? DIGIT_COUNT : 4;

  localparam int WORD_W  = 32;
  localparam int COUNT_W = 14;
  localparam int KEY_W   = 8;
  localparam int DP_BIT  = 15;

  // input item kinds
  localparam logic MODE_TICK = 1'b0;
  localparam logic MODE_KEY  = 1'b1;

  // keypad codes
  localparam logic [KEY_W-1:0] KEY_PAUSE  = 8'h23;  // '#'
  localparam logic [KEY_W-1:0] KEY_RESUME = 8'h2A;  // '*'
  localparam logic [KEY_W-1:0] KEY_CLEAR  = 8'h30;  // '0'

  localparam logic [3:0] DIGIT_NINE = 4'd9;

  typedef logic [3:0] digit_t;
  typedef digit_t [DIGIT_COUNT-1:0] digits_t;

  // one item leaving the input register
  typedef struct packed {
    logic             fire;
    logic             mode;
    logic [KEY_W-1:0] key_code;
  } step_t;

  // seven-segment pattern of one decimal digit, blank for non-decimal codes
  function automatic logic [7:0] seg_of(input digit_t d);
    logic [7:0] p;
    case (d)
      4'd0:    p = 8'd63;
      4'd1:    p = 8'd6;
      4'd2:    p = 8'd91;
      4'd3:    p = 8'd79;
      4'd4:    p = 8'd102;
      4'd5:    p = 8'd109;
      4'd6:    p = 8'd125;
      4'd7:    p = 8'd7;
      4'd8:    p = 8'd127;
      4'd9:    p = 8'd103;
      default: p = 8'd0;
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

>>> hdl/sssc_count.sv
// ----------------------------------------------------------------------------
// sssc_count
// Holds the decimal digits and the run flag; applies one item per fire.
// ----------------------------------------------------------------------------
`default_nettype none

module sssc_count (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire sssc_pkg::step_t step,
  output logic                 running,
  output logic                 produce,
  output sssc_pkg::digits_t    digits_inc
);
  import sssc_pkg::*;

  digits_t digits;
  digits_t digits_next;
  logic    running_next;
  logic    carry;

  // ripple decimal increment, wrapping all nines to zero
  always_comb begin
    carry = 1'b1;
    for (int k = 0; k < DIGIT_COUNT; k++) begin
      if (!carry) begin
        digits_inc[k] = digits[k];
      end else if (digits[k] >= DIGIT_NINE) begin
        digits_inc[k] = '0;
      end else begin
        digits_inc[k] = digits[k] + 4'd1;
        carry = 1'b0;
      end
    end
  end

  assign produce = step.fire && (step.mode == MODE_TICK) && running;

  // next state for ticks and keys
  always_comb begin
    digits_next  = digits;
    running_next = running;
    if (step.fire) begin
      if (step.mode == MODE_KEY) begin
        if (running) begin
          if (step.key_code == KEY_PAUSE) running_next = 1'b0;
        end else if (step.key_code == KEY_RESUME) begin
          running_next = 1'b1;
        end else if (step.key_code == KEY_CLEAR) begin
          digits_next = '0;
        end
      end else if (running) begin
        digits_next = digits_inc;
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      digits  <= '0;
      running <= 1'b1;
    end else begin
      digits  <= digits_next;
      running <= running_next;
    end
  end

endmodule

`default_nettype wire

>>> hdl/sssc_decode.sv
// ----------------------------------------------------------------------------
// sssc_decode
// Turns the digit vector into the segment word and the binary count.
// ----------------------------------------------------------------------------
`default_nettype none

module sssc_decode (
  input  wire sssc_pkg::digits_t                  digits,
  output logic [sssc_pkg::WORD_W-1:0]             word,
  output logic [sssc_pkg::COUNT_W-1:0]            count
);
  import sssc_pkg::*;

  logic [DIGIT_COUNT-1:0] show;
  logic                   nz_acc;
  logic                   above_nine;

  // a digit is lit when it or any higher digit is nonzero; digit 0 always
  always_comb begin
    nz_acc = 1'b0;
    for (int k = DIGIT_COUNT - 1; k >= 0; k--) begin
      nz_acc  = nz_acc | (digits[k] != 4'd0);
      show[k] = nz_acc | (k == 0);
    end
  end

  // count exceeds nine once any digit above the first is nonzero
  always_comb begin
    above_nine = 1'b0;
    for (int k = 1; k < DIGIT_COUNT; k++) begin
      above_nine = above_nine | (digits[k] != 4'd0);
    end
  end

  // segment bytes plus decimal point
  always_comb begin
    word = '0;
    for (int k = 0; k < SHOWN_DIGITS; k++) begin
      if (show[k]) word[8*k +: 8] = seg_of(digits[k]);
    end
    if (above_nine) word[DP_BIT] = 1'b1;
  end

  // decimal to binary, kept to the count width
  always_comb begin
    count = '0;
    for (int k = DIGIT_COUNT - 1; k >= 0; k--) begin
      count = COUNT_W'(count * COUNT_W'(10)) + COUNT_W'(digits[k]);
    end
  end

endmodule

`default_nettype wire

>>> hdl/stopwatch_seven_segment_counter.sv
// ----------------------------------------------------------------------------
// stopwatch_seven_segment_counter
// Tenths-of-a-second stopwatch with seven-segment display word output.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one item: mode 0 is a timer
//   tick, mode 1 a keypad key in key_code. '#' pauses, '*' resumes, and '0'
//   clears the count while paused; other keys are dropped.
//   Output channel (out_valid/out_ready) carries one item per tick taken
//   while running: segment_word (digit 0 in the low byte, leading zeros
//   blank, bit 15 decimal point) and shown_count. Keys and paused ticks
//   give no output item.
//   An accepted item waits in the input register and, when it moves on, is
//   applied and its result loaded into the output register and offered.
//   Throughput: one item per cycle while not stalled, set by the single
//   input register feeding digit update and decode into the output register.
//   Reset clears the count to zero and starts in the running state.
//   When the receiver stalls, the held result waits in the output register;
//   one more item is taken into the input register; keys and paused ticks
//   move on as they give no result, but a running tick held there stalls it.
// ----------------------------------------------------------------------------
`default_nettype none

module stopwatch_seven_segment_counter (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic                         mode,
  input  wire logic [sssc_pkg::KEY_W-1:0]   key_code,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [sssc_pkg::WORD_W-1:0]       segment_word,
  output logic [sssc_pkg::COUNT_W-1:0]      shown_count
);
  import sssc_pkg::*;

  logic               s1_valid;
  logic               s1_mode;
  logic [KEY_W-1:0]   s1_key;
  logic               advance;
  logic               running;
  logic               produce;
  step_t              step;
  digits_t            digits_inc;
  logic [WORD_W-1:0]  word_calc;
  logic [COUNT_W-1:0] count_calc;

  // the held item moves on unless it makes a result that has nowhere to go
  assign step.mode     = s1_mode;
  assign step.key_code = s1_key;
  assign step.fire     = advance;
  assign advance = s1_valid &&
                   (!(s1_mode == MODE_TICK && running) || !out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_mode <= mode;
      s1_key  <= key_code;
    end
  end

  sssc_count u_count (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .running    (running),
    .produce    (produce),
    .digits_inc (digits_inc)
  );

  sssc_decode u_decode (
    .digits (digits_inc),
    .word   (word_calc),
    .count  (count_calc)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (produce) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (produce) begin
      segment_word <= word_calc;
      shown_count  <= count_calc;
    end
  end

  // checks
  a_key_no_result: assert property (@(posedge clk) disable iff (rst)
    advance && s1_mode == MODE_KEY && out_valid && out_ready |=> !out_valid)
    else $error("key item produced a result");

  a_digit0_lit: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> segment_word[7:0] != 8'd0)
    else $error("lowest digit blank");

  a_zero_no_dp: assert property (@(posedge clk) disable iff (rst)
    out_valid && shown_count == '0 |-> segment_word[DP_BIT] == 1'b0)
    else $error("decimal point shown on zero count");

  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> s1_valid && out_valid && !out_ready)
    else $error("input stalled without a full output");

endmodule

`default_nettype wire

>>> tb/stopwatch_seven_segment_counter_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stopwatch_seven_segment_counter_test
// Self-checking bench for the tenths-of-a-second stopwatch. Ticks and keypad
// items are pushed through the input handshake while a local model of the
// digits and the run/pause flag predicts each display word. Every output item
// is compared against the oldest prediction, under random idling on both
// sides, a long receiver hold-off and a carry into the hundreds digit.
// ----------------------------------------------------------------------------

module stopwatch_seven_segment_counter_test;

  import sssc_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_LIMIT = 2000;
  localparam int HOLD_CYCLES = 200;
  localparam int TAIL_CYCLES = 8;
  localparam int RANDOM_ITEMS = 200;
  localparam int CARRY_TICKS = 105;

  // segment patterns for decimal digits, blank for anything else
  localparam logic [7:0] DIGIT_SEGMENTS [16] = '{
    8'd63, 8'd6, 8'd91, 8'd79, 8'd102, 8'd109, 8'd125, 8'd7, 8'd127, 8'd103,
    8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0
  };

  typedef struct packed {
    logic [WORD_W-1:0]  segment_word;
    logic [COUNT_W-1:0] shown_count;
  } watch_display_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               mode = MODE_TICK;
  logic [KEY_W-1:0]   key_code = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [WORD_W-1:0]  segment_word;
  logic [COUNT_W-1:0] shown_count;

  // model of the watch and predicted displays
  digits_t        watch_digits = '0;
  logic           watch_running = 1'b1;
  watch_display_t pending_displays [$];

  int  mismatch_count = 0;
  int  cycle_count = 0;
  bit  steady_flow = 1'b0;
  bit  hold_request = 1'b0;

  stopwatch_seven_segment_counter uut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .mode         (mode),
    .key_code     (key_code),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .segment_word (segment_word),
    .shown_count  (shown_count)
  );

  always #2 clk = ~clk;

  // run time guard
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // display word for a given set of digits
  function automatic watch_display_t display_of(input digits_t d);
    watch_display_t r;
    int             top;
    logic [31:0]    value;
    top = 0;
    value = '0;
    for (int k = 0; k < DIGIT_COUNT; k++)
      if (d[k] != 4'd0) top = k;
    for (int k = DIGIT_COUNT - 1; k >= 0; k--)
      value = value * 10 + d[k];
    r.segment_word = '0;
    for (int k = 0; k <= top && k < SHOWN_DIGITS; k++)
      r.segment_word[8*k +: 8] = DIGIT_SEGMENTS[d[k]];
    if (value > 9) r.segment_word[DP_BIT] = 1'b1;
    r.shown_count = value[COUNT_W-1:0];
    return r;
  endfunction

  // apply one accepted item to the watch model
  function automatic void predict_watch_item(input logic m, input logic [KEY_W-1:0] k);
    logic carry;
    if (m == MODE_KEY) begin
      if (watch_running) begin
        if (k == KEY_PAUSE) watch_running = 1'b0;
      end else if (k == KEY_RESUME) begin
        watch_running = 1'b1;
      end else if (k == KEY_CLEAR) begin
        watch_digits = '0;
      end
    end else if (watch_running) begin
      carry = 1'b1;
      for (int i = 0; i < DIGIT_COUNT && carry; i++) begin
        if (watch_digits[i] >= DIGIT_NINE) begin
          watch_digits[i] = 4'd0;
        end else begin
          watch_digits[i] = watch_digits[i] + 4'd1;
          carry = 1'b0;
        end
      end
      pending_displays.push_back(display_of(watch_digits));
    end
  endfunction

  // input side: predict on every accepted item
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) predict_watch_item(mode, key_code);
  end

  // output side: compare every accepted item with the oldest prediction
  always @(posedge clk) begin
    watch_display_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_displays.size() == 0) begin
        $error("unexpected output item: segment_word %h shown_count %0d",
               segment_word, shown_count);
        mismatch_count++;
      end else begin
        want = pending_displays.pop_front();
        if (segment_word !== want.segment_word) begin
          $error("segment_word: expected %h, got %h", want.segment_word, segment_word);
          mismatch_count++;
        end
        if (shown_count !== want.shown_count) begin
          $error("shown_count: expected %0d, got %0d", want.shown_count, shown_count);
          mismatch_count++;
        end
      end
    end
  end

  // receiver with random stalls and an occasional long hold-off
  initial begin
    forever begin
      @(posedge clk);
      if (hold_request) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
      end else begin
        out_ready <= steady_flow || ($urandom_range(99) >= 6);
      end
    end
  end

  // offer one item and return at the edge that takes it
  task automatic send_item(input logic m, input logic [KEY_W-1:0] k);
    if (!steady_flow) begin
      while ($urandom_range(99) < 6) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    mode     <= m;
    key_code <= k;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // stop offering and wait for every predicted display
  task automatic wait_drained();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_displays.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
  endtask

  // pause, clear and resume, whatever state the watch is in
  task automatic restart_from_zero();
    send_item(MODE_KEY, KEY_PAUSE);
    send_item(MODE_KEY, KEY_CLEAR);
    send_item(MODE_KEY, KEY_RESUME);
  endtask

  // counting up from reset, across the first decimal point
  task automatic test_first_ticks();
    send_item(MODE_TICK, 8'h00);
    send_item(MODE_TICK, 8'hFF);
    for (int i = 0; i < 9; i++) send_item(MODE_TICK, KEY_PAUSE);
  endtask

  // every key in both states, paused ticks and odd codes
  task automatic test_keypad();
    send_item(MODE_KEY, KEY_RESUME);
    send_item(MODE_KEY, KEY_CLEAR);
    send_item(MODE_KEY, 8'hFF);
    send_item(MODE_KEY, KEY_PAUSE);
    send_item(MODE_TICK, 8'h00);
    send_item(MODE_KEY, KEY_PAUSE);
    send_item(MODE_KEY, 8'h00);
    send_item(MODE_KEY, KEY_CLEAR);
    send_item(MODE_TICK, 8'hFF);
    send_item(MODE_KEY, KEY_RESUME);
    send_item(MODE_TICK, KEY_CLEAR);
    send_item(MODE_TICK, KEY_RESUME);
  endtask

  // from zero past ninety-nine, carrying into the hundreds digit
  task automatic test_hundreds_carry();
    restart_from_zero();
    for (int i = 0; i < CARRY_TICKS; i++) send_item(MODE_TICK, KEY_W'($urandom));
  endtask

  // mostly ticks with random key traffic, one stretch without idling
  task automatic test_random_mix();
    int pick;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      steady_flow = (i >= 60 && i < 140);
      pick = $urandom_range(99);
      if (pick < 65)      send_item(MODE_TICK, KEY_W'($urandom));
      else if (pick < 75) send_item(MODE_KEY, KEY_PAUSE);
      else if (pick < 84) send_item(MODE_KEY, KEY_RESUME);
      else if (pick < 90) send_item(MODE_KEY, KEY_CLEAR);
      else                send_item(MODE_KEY, KEY_W'($urandom));
    end
    steady_flow = 1'b0;
  endtask

  // receiver holds off while the sender keeps offering ticks
  task automatic test_output_hold();
    restart_from_zero();
    steady_flow = 1'b1;
    hold_request = 1'b1;
    for (int i = 0; i < 40; i++)
      send_item((i % 7 == 3) ? MODE_KEY : MODE_TICK, KEY_W'($urandom));
    steady_flow = 1'b0;
    wait_drained();
  endtask

  // sender pauses for a full drain, then carries on
  task automatic test_drain_pause();
    for (int i = 0; i < 10; i++) send_item(MODE_TICK, KEY_W'($urandom));
    wait_drained();
    for (int i = 0; i < 10; i++)
      send_item(($urandom_range(3) == 0) ? MODE_KEY : MODE_TICK, KEY_W'($urandom));
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_first_ticks();
    test_keypad();
    test_hundreds_carry();
    test_output_hold();
    test_drain_pause();
    test_random_mix();

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_displays.size() != 0) begin
      $error("%0d predicted displays never arrived", pending_displays.size());
      mismatch_count++;
    end

    if (mismatch_count == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
